### hw/rtl/tcsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcsa_pkg: shared codes and helpers for the triplet cover scorer
// Operation codes, register indexes, the reset weight and a 64-bit popcount.
// ----------------------------------------------------------------------------
package tcsa_pkg;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_SCORE  = 2'd1,
      OP_COMMIT = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   localparam logic [1:0] CSR_ALPHA        = 2'd0;
   localparam logic [1:0] CSR_TUMOR_TOTAL  = 2'd1;
   localparam logic [1:0] CSR_NORMAL_TOTAL = 2'd2;

   // Roughly 0.1 in unsigned Q4.12.
   localparam logic [15:0] ALPHA_RESET = 16'd410;

   // Bit-parallel population count; each byte lane holds a partial sum until
   // the final folds, and the total of at most 64 fits the low byte.
   function automatic logic [6:0] popcount64(input logic [63:0] x);
      logic [63:0] s1;
      logic [63:0] s2;
      logic [63:0] s3;
      logic [63:0] s4;
      logic [63:0] s5;
      logic [63:0] s6;
      s1 = x - ((x >> 1) & 64'h5555_5555_5555_5555);
      s2 = (s1 & 64'h3333_3333_3333_3333) + ((s1 >> 2) & 64'h3333_3333_3333_3333);
      s3 = (s2 + (s2 >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
      s4 = s3 + (s3 >> 8);
      s5 = s4 + (s4 >> 16);
      s6 = s5 + (s5 >> 32);
      return s6[6:0];
   endfunction

endpackage

### hw/rtl/triplet_cover_score_argmax.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triplet_cover_score_argmax: greedy three-gene set-cover scorer
// Stores per-gene tumor/normal bitmaps, scores triplets, keeps the best one
// of the round and commits it into the covered-sample mask.
// ----------------------------------------------------------------------------
// Both bitmaps of a gene word live side by side in one RAM with a single read
// port, so a score or a commit reads the three genes of each 64-sample word
// one after another; a commit with a kept triplet skips the multiply state.
// Loads, no-ops and commits of an empty round read no bitmaps. The block
// takes one request at a time and raises req_stall until its result is in
// the output register; a waiting result does not block the next request.
module triplet_cover_score_argmax
   import tcsa_pkg::*;
#(
   parameter int GENES   = 1024,
   parameter int SAMPLES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [9:0]  req_gene_a,
   input  logic [9:0]  req_gene_b,
   input  logic [9:0]  req_gene_c,
   input  logic [1:0]  req_word_index,
   input  logic [63:0] req_tumor_word,
   input  logic [63:0] req_normal_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [8:0]  rsp_true_pos,
   output logic [8:0]  rsp_false_pos,
   output logic [24:0] rsp_score,
   output logic [9:0]  rsp_best_a,
   output logic [9:0]  rsp_best_b,
   output logic [9:0]  rsp_best_c,
   output logic [24:0] rsp_best_score,
   output logic        rsp_best_valid,
   output logic [9:0]  rsp_denominator,
   output logic [8:0]  rsp_covered_now,
   output logic        rsp_all_covered,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int WORDS = SAMPLES / 64;
   localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int DEPTH = GENES * WORDS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(SAMPLES + 1);
   localparam int EW    = (CW > 9) ? CW : 9;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_READ  = 5'b00010,
      S_DRAIN = 5'b00100,
      S_MUL   = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   // Configuration registers.
   logic [15:0] alpha_ff;
   logic [8:0]  tumor_total_ff;
   logic [8:0]  normal_total_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff        <= ALPHA_RESET;
         tumor_total_ff  <= '0;
         normal_total_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ALPHA:        alpha_ff        <= csr_data;
            CSR_TUMOR_TOTAL:  tumor_total_ff  <= csr_data[8:0];
            CSR_NORMAL_TOTAL: normal_total_ff <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   // Sequencer and request capture.
   state_type  state_ff, state_in;
   op_type     op_ff;
   op_type     req_op;
   logic [9:0] gene_ff [3];
   logic [1:0] k_ff;
   logic [WW-1:0] w_ff;
   logic       req_fire;
   logic       last_issue;
   logic       drained;
   logic       out_write;

   // Best-of-round and cover state.
   logic [9:0]  best_a_ff, best_b_ff, best_c_ff;
   logic [24:0] best_value_ff;
   logic        best_seen_ff;
   logic [8:0]  covered_count_ff;
   logic [63:0] present_ff [WORDS];
   logic [63:0] covered_ff [WORDS];
   logic [WORDS-1:0] unc_ff;

   assign req_op     = op_type'(req_operation);
   assign req_stall  = (state_ff != S_IDLE);
   assign req_fire   = req_valid && !req_stall;
   assign last_issue = (k_ff == 2'd2) && (w_ff == WW'(WORDS - 1));

   // Bitmap RAM: {normal, tumor} per gene word.
   logic          ld_en;
   logic [WW-1:0] ld_w;
   logic [AW-1:0] ld_addr;
   logic [9:0]    gsel;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [127:0]  rd_data;

   assign ld_w    = WW'(req_word_index);
   assign ld_en   = req_fire && (req_op == OP_LOAD) && (32'(req_gene_a) < GENES)
                    && (32'(req_word_index) < WORDS);
   assign ld_addr = AW'(32'(req_gene_a) * WORDS + 32'(req_word_index));
   assign gsel    = gene_ff[k_ff];
   assign rd_en   = (state_ff == S_READ);
   assign rd_addr = AW'(32'(gsel) * WORDS + 32'(w_ff));

   tcsa_ram #(
      .WIDTH (128),
      .DEPTH (DEPTH)
   ) u_bitmap_ram (
      .clock   (clock),
      .wr_en   (ld_en),
      .wr_addr (ld_addr),
      .wr_data ({req_normal_word, req_tumor_word}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Read tags are registered alongside the RAM read so they line up with its data.
   logic          rd_vld_ff;
   logic          rd_ok_ff;
   logic [1:0]    rd_k_ff;
   logic [WW-1:0] rd_w_ff;
   logic [63:0]   data_t, data_n;
   logic [63:0]   acc_t_ff, acc_n_ff;
   logic          pc_vld_ff;
   logic [63:0]   pc_t_ff, pc_n_ff;
   logic [WW-1:0] pc_w_ff;
   logic [63:0]   hit;
   logic [6:0]    pop_t, pop_n;
   logic [CW-1:0] tp_ff, fp_ff;

   // A gene beyond the store reads as an empty bitmap.
   assign data_t = rd_ok_ff ? rd_data[63:0]   : '0;
   assign data_n = rd_ok_ff ? rd_data[127:64] : '0;
   assign hit    = pc_t_ff & ~covered_ff[pc_w_ff];
   assign pop_t  = popcount64(hit);
   assign pop_n  = popcount64(pc_n_ff);
   assign drained = !rd_vld_ff && !pc_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         pc_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= rd_en;
         pc_vld_ff <= rd_vld_ff && (rd_k_ff == 2'd2);
      end
   end

   always_ff @(posedge clock) begin
      rd_ok_ff <= (32'(gsel) < GENES);
      rd_k_ff  <= k_ff;
      rd_w_ff  <= w_ff;
      if (rd_vld_ff) begin
         if (rd_k_ff == 2'd0) begin
            acc_t_ff <= data_t;
            acc_n_ff <= data_n;
         end else begin
            acc_t_ff <= acc_t_ff & data_t;
            acc_n_ff <= acc_n_ff & data_n;
         end
      end
      pc_t_ff <= acc_t_ff & data_t;
      pc_n_ff <= acc_n_ff & data_n;
      pc_w_ff <= rd_w_ff;
   end

   // Word and gene counters, request capture, count accumulation.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff <= req_op;
         k_ff  <= '0;
         w_ff  <= '0;
         tp_ff <= '0;
         fp_ff <= '0;
         if (req_op == OP_COMMIT) begin
            gene_ff[0] <= best_a_ff;
            gene_ff[1] <= best_b_ff;
            gene_ff[2] <= best_c_ff;
         end else begin
            gene_ff[0] <= req_gene_a;
            gene_ff[1] <= req_gene_b;
            gene_ff[2] <= req_gene_c;
         end
      end else begin
         if (rd_en) begin
            if (k_ff == 2'd2) begin
               k_ff <= '0;
               w_ff <= w_ff + 1'b1;
            end else begin
               k_ff <= k_ff + 1'b1;
            end
         end
         if (pc_vld_ff) begin
            tp_ff <= tp_ff + CW'(pop_t);
            fp_ff <= fp_ff + CW'(pop_n);
         end
      end
   end

   // Present and covered masks, with a per-word flag of uncovered samples.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WORDS; i++) begin
            present_ff[i] <= '0;
            covered_ff[i] <= '0;
         end
         unc_ff <= '0;
      end else if (ld_en) begin
         present_ff[ld_w] <= present_ff[ld_w] | req_tumor_word;
         unc_ff[ld_w]     <= |((present_ff[ld_w] | req_tumor_word) & ~covered_ff[ld_w]);
      end else if (pc_vld_ff && (op_ff == OP_COMMIT)) begin
         covered_ff[pc_w_ff] <= covered_ff[pc_w_ff] | hit;
         unc_ff[pc_w_ff]     <= |(present_ff[pc_w_ff] & ~(covered_ff[pc_w_ff] | hit));
      end
   end

   // Score arithmetic: the product is registered in S_MUL, the sum is combinational.
   logic [24:0]   prod_ff;
   logic [8:0]    tn_ff;
   logic [EW-1:0] nt_ext, fp_ext;
   logic [24:0]   sc_score;
   logic          take_best;

   assign nt_ext = EW'(normal_total_ff);
   assign fp_ext = EW'(fp_ff);

   always_ff @(posedge clock) begin
      if (state_ff == S_MUL) begin
         prod_ff <= 25'(alpha_ff) * 25'(tp_ff);
         tn_ff   <= (nt_ext > fp_ext) ? 9'(nt_ext - fp_ext) : '0;
      end
   end

   assign sc_score  = prod_ff + 25'({tn_ff, 12'd0});
   assign take_best = (op_ff == OP_SCORE) && (!best_seen_ff || (sc_score > best_value_ff));
   assign out_write = (state_ff == S_DONE) && (!rsp_valid || !rsp_stall);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_op == OP_SCORE || (req_op == OP_COMMIT && best_seen_ff)) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_READ: begin
            if (last_issue) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (drained) begin
               state_in = (op_ff == OP_SCORE) ? S_MUL : S_DONE;
            end
         end
         S_MUL: state_in = S_DONE;
         S_DONE: begin
            if (out_write) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Round state and covered count change as the result is written out.
   logic [8:0]  rem;
   logic [9:0]  den;
   logic [EW:0] cc_sum;

   assign rem    = (tumor_total_ff > covered_count_ff) ? (tumor_total_ff - covered_count_ff)
                                                        : '0;
   assign den    = 10'(rem) + 10'(normal_total_ff);
   assign cc_sum = (EW + 1)'(covered_count_ff) + (EW + 1)'(tp_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         best_a_ff        <= '0;
         best_b_ff        <= '0;
         best_c_ff        <= '0;
         best_value_ff    <= '0;
         best_seen_ff     <= 1'b0;
         covered_count_ff <= '0;
      end else if (out_write) begin
         if (take_best) begin
            best_seen_ff  <= 1'b1;
            best_value_ff <= sc_score;
            best_a_ff     <= gene_ff[0];
            best_b_ff     <= gene_ff[1];
            best_c_ff     <= gene_ff[2];
         end else if (op_ff == OP_COMMIT) begin
            best_seen_ff     <= 1'b0;
            best_value_ff    <= '0;
            best_a_ff        <= '0;
            best_b_ff        <= '0;
            best_c_ff        <= '0;
            covered_count_ff <= (cc_sum > (EW + 1)'(511)) ? 9'd511 : 9'(cc_sum);
         end
      end
   end

   // Output register.
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (out_write) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_write) begin
         rsp_true_pos    <= (op_ff == OP_SCORE) ? 9'(tp_ff) : '0;
         rsp_false_pos   <= (op_ff == OP_SCORE) ? 9'(fp_ff) : '0;
         case (op_ff)
            OP_SCORE:  rsp_score <= sc_score;
            OP_COMMIT: rsp_score <= best_value_ff;
            default:   rsp_score <= '0;
         endcase
         rsp_best_a      <= take_best ? gene_ff[0] : best_a_ff;
         rsp_best_b      <= take_best ? gene_ff[1] : best_b_ff;
         rsp_best_c      <= take_best ? gene_ff[2] : best_c_ff;
         rsp_best_score  <= take_best ? sc_score : best_value_ff;
         rsp_best_valid  <= take_best || best_seen_ff;
         rsp_denominator <= den;
         rsp_covered_now <= (op_ff == OP_COMMIT) ? 9'(tp_ff) : '0;
         rsp_all_covered <= ~|unc_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // A new result appears only out of the final state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) |-> $past(state_ff == S_DONE)))
      else $error("result raised outside the final state");

   // The read pipeline is empty before the score is formed.
   a_drained_mul: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_MUL) |-> (!rd_vld_ff && !pc_vld_ff)))
      else $error("score formed while bitmap reads are in flight");

   // Word popcounts land only while the triplet is being read.
   a_pc_in_read: assert property (@(posedge clock) disable iff (reset)
      (pc_vld_ff |-> (state_ff == S_READ || state_ff == S_DRAIN)))
      else $error("popcount stage active outside the read phase");

   // A commit always opens an empty round.
   a_commit_clears: assert property (@(posedge clock) disable iff (reset)
      ((out_write && (op_ff == OP_COMMIT)) |=> !best_seen_ff))
      else $error("best triplet survived a commit");

endmodule

### hw/rtl/tcsa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcsa_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tcsa_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 4096,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for triplet_cover_score_argmax
// Loads gene bitmaps, scores triplets and commits the best of each round while
// an in-bench predictor tracks stores, masks and the round's best triplet.
// Every response is compared field by field against the predicted one.
// ----------------------------------------------------------------------------
module testbench
   import tcsa_pkg::*;
;

   localparam int GENE_COUNT      = 1024;
   localparam int WORD_COUNT      = 4;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int DRAIN_CYCLES    = 40;

   typedef struct {
      op_type      op;
      logic [9:0]  gene_a;
      logic [9:0]  gene_b;
      logic [9:0]  gene_c;
      logic [1:0]  word_index;
      logic [63:0] tumor_word;
      logic [63:0] normal_word;
   } request_type;

   typedef struct {
      logic [8:0]  true_pos;
      logic [8:0]  false_pos;
      logic [24:0] score;
      logic [9:0]  best_a;
      logic [9:0]  best_b;
      logic [9:0]  best_c;
      logic [24:0] best_score;
      logic        best_valid;
      logic [9:0]  denominator;
      logic [8:0]  covered_now;
      logic        all_covered;
   } cover_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = OP_NOP;
   logic [9:0]  req_gene_a = '0;
   logic [9:0]  req_gene_b = '0;
   logic [9:0]  req_gene_c = '0;
   logic [1:0]  req_word_index = '0;
   logic [63:0] req_tumor_word = '0;
   logic [63:0] req_normal_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [8:0]  rsp_true_pos;
   logic [8:0]  rsp_false_pos;
   logic [24:0] rsp_score;
   logic [9:0]  rsp_best_a;
   logic [9:0]  rsp_best_b;
   logic [9:0]  rsp_best_c;
   logic [24:0] rsp_best_score;
   logic        rsp_best_valid;
   logic [9:0]  rsp_denominator;
   logic [8:0]  rsp_covered_now;
   logic        rsp_all_covered;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_ALPHA;
   logic [15:0] csr_data = '0;

   // Predicted block state and register copies.
   bit   [63:0] tumor_bits [GENE_COUNT][WORD_COUNT];
   bit   [63:0] normal_bits [GENE_COUNT][WORD_COUNT];
   logic [63:0] present_bits [WORD_COUNT];
   logic [63:0] covered_bits [WORD_COUNT];
   int unsigned covered_total;
   logic [9:0]  kept_a;
   logic [9:0]  kept_b;
   logic [9:0]  kept_c;
   logic [24:0] kept_score;
   logic        kept_seen;
   logic [15:0] alpha_cfg;
   logic [8:0]  tumor_total_cfg;
   logic [8:0]  normal_total_cfg;

   // Stimulus bookkeeping: only genes with all four words loaded are scored.
   logic [3:0]  loaded_words [GENE_COUNT];
   bit          gene_ready [GENE_COUNT];
   int          ready_genes [$];

   cover_result_type pending_results [$];
   int          sent_items = 0;
   int          fail_count = 0;
   int          cycle_count = 0;
   bit          no_idle = 1'b0;
   int          hold_off_requests = 0;
   int          hold_off_served = 0;
   int          hold_left = 0;

   triplet_cover_score_argmax i_dut (.*);

   always #2 clock = ~clock;

   function automatic cover_result_type predict_cover_step(input request_type r);
      cover_result_type res;
      int unsigned   tp;
      int unsigned   fp;
      int unsigned   tn;
      int unsigned   remaining;
      int unsigned   newly;
      logic [63:0]   hit;
      logic [63:0]   weighted;
      int            w;
      res = '{default: '0};
      tp = 0;
      fp = 0;
      newly = 0;
      remaining = (tumor_total_cfg > covered_total) ? tumor_total_cfg - covered_total : 0;
      res.denominator = 10'(remaining + normal_total_cfg);
      case (r.op)
         OP_LOAD: begin
            tumor_bits[r.gene_a][r.word_index] = r.tumor_word;
            normal_bits[r.gene_a][r.word_index] = r.normal_word;
            present_bits[r.word_index] |= r.tumor_word;
         end
         OP_SCORE: begin
            for (w = 0; w < WORD_COUNT; w++) begin
               tp += $countones(tumor_bits[r.gene_a][w] & tumor_bits[r.gene_b][w] &
                                tumor_bits[r.gene_c][w] & ~covered_bits[w]);
               fp += $countones(normal_bits[r.gene_a][w] & normal_bits[r.gene_b][w] &
                                normal_bits[r.gene_c][w]);
            end
            tn = (normal_total_cfg > fp) ? normal_total_cfg - fp : 0;
            weighted = 64'(alpha_cfg) * 64'(tp) + (64'(tn) << 12);
            res.true_pos = 9'(tp);
            res.false_pos = 9'(fp);
            res.score = weighted[24:0];
            // An empty round takes any score; after that only a strictly
            // greater one replaces the kept triplet.
            if (!kept_seen || res.score > kept_score) begin
               kept_seen = 1'b1;
               kept_score = res.score;
               kept_a = r.gene_a;
               kept_b = r.gene_b;
               kept_c = r.gene_c;
            end
         end
         default: begin
         end
      endcase
      res.best_a = kept_a;
      res.best_b = kept_b;
      res.best_c = kept_c;
      res.best_score = kept_score;
      res.best_valid = kept_seen;
      if (r.op == OP_COMMIT) begin
         if (kept_seen) begin
            for (w = 0; w < WORD_COUNT; w++) begin
               hit = tumor_bits[kept_a][w] & tumor_bits[kept_b][w] &
                     tumor_bits[kept_c][w] & ~covered_bits[w];
               newly += $countones(hit);
               covered_bits[w] |= hit;
            end
            covered_total = (covered_total + newly > 511) ? 511 : covered_total + newly;
         end
         res.score = kept_score;
         res.covered_now = 9'(newly);
         kept_seen = 1'b0;
         kept_score = '0;
         kept_a = '0;
         kept_b = '0;
         kept_c = '0;
      end
      res.all_covered = 1'b1;
      for (w = 0; w < WORD_COUNT; w++) begin
         if (|(present_bits[w] & ~covered_bits[w])) res.all_covered = 1'b0;
      end
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   // Response checker: every accepted response is matched to the oldest prediction.
   always @(posedge clock) begin
      cover_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_results.size() == 0) begin
            fail_count++;
            $display("%0t ns: response with no request outstanding", $time);
         end else begin
            want = pending_results.pop_front();
            check_field("true_pos", want.true_pos, rsp_true_pos);
            check_field("false_pos", want.false_pos, rsp_false_pos);
            check_field("score", want.score, rsp_score);
            check_field("best_a", want.best_a, rsp_best_a);
            check_field("best_b", want.best_b, rsp_best_b);
            check_field("best_c", want.best_c, rsp_best_c);
            check_field("best_score", want.best_score, rsp_best_score);
            check_field("best_valid", want.best_valid, rsp_best_valid);
            check_field("denominator", want.denominator, rsp_denominator);
            check_field("covered_now", want.covered_now, rsp_covered_now);
            check_field("all_covered", want.all_covered, rsp_all_covered);
         end
      end
   end

   // Response side: random stalls, or a long counted hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_off_served != hold_off_requests) begin
         hold_off_served = hold_off_requests;
         hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall = 1'b1;
      end else if (no_idle) begin
         rsp_stall = 1'b0;
      end else begin
         rsp_stall = ($urandom_range(99) < 20);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t ns: cycle limit of %0d reached", $time, CYCLE_LIMIT);
      $display("** triplet_cover_score_argmax: FAILED **");
      $finish;
   end

   function automatic logic [63:0] random_tumor_word();
      logic [63:0] x;
      logic [63:0] y;
      x = {$urandom, $urandom};
      y = {$urandom, $urandom};
      case ($urandom_range(3))
         0: return x;
         1: return x | y;
         2: return x & y;
         default: return '1;
      endcase
   endfunction

   function automatic logic [63:0] random_normal_word();
      logic [63:0] x;
      logic [63:0] y;
      x = {$urandom, $urandom};
      y = {$urandom, $urandom};
      case ($urandom_range(3))
         0: return x;
         1: return '0;
         default: return x | y;
      endcase
   endfunction

   function automatic request_type make_request(input op_type op, input logic [9:0] a,
                                                input logic [9:0] b, input logic [9:0] c);
      request_type r;
      r.op = op;
      r.gene_a = a;
      r.gene_b = b;
      r.gene_c = c;
      r.word_index = 2'($urandom_range(3));
      r.tumor_word = {$urandom, $urandom};
      r.normal_word = {$urandom, $urandom};
      return r;
   endfunction

   function automatic logic [9:0] pick_ready_gene();
      return 10'(ready_genes[$urandom_range(ready_genes.size() - 1)]);
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance with
   // req_valid still high, so the next request follows without a bubble.
   task automatic send_request(input request_type r);
      if (!no_idle) begin
         while ($urandom_range(99) < 20) begin
            req_valid = 1'b0;
            @(negedge clock);
         end
      end
      req_operation = r.op;
      req_gene_a = r.gene_a;
      req_gene_b = r.gene_b;
      req_gene_c = r.gene_c;
      req_word_index = r.word_index;
      req_tumor_word = r.tumor_word;
      req_normal_word = r.normal_word;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_results.push_back(predict_cover_step(r));
      sent_items++;
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [15:0] data);
      csr_index = idx;
      csr_data = data;
      csr_valid = 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_ALPHA:        alpha_cfg = data;
         CSR_TUMOR_TOTAL:  tumor_total_cfg = data[8:0];
         CSR_NORMAL_TOTAL: normal_total_cfg = data[8:0];
         default: begin
         end
      endcase
      @(negedge clock);
   endtask

   // Only called with the block idle and no request outstanding.
   task automatic set_config(input logic [15:0] alpha, input logic [15:0] tumors,
                             input logic [15:0] normals);
      write_register(CSR_ALPHA, alpha);
      write_register(CSR_TUMOR_TOTAL, tumors);
      write_register(CSR_NORMAL_TOTAL, normals);
      csr_valid = 1'b0;
   endtask

   task automatic load_word(input logic [9:0] gene, input logic [1:0] word,
                            input logic [63:0] tumors, input logic [63:0] normals);
      request_type r;
      r = make_request(OP_LOAD, gene, 10'($urandom_range(1023)), 10'($urandom_range(1023)));
      r.word_index = word;
      r.tumor_word = tumors;
      r.normal_word = normals;
      send_request(r);
      loaded_words[gene][word] = 1'b1;
      if (loaded_words[gene] == 4'hF && !gene_ready[gene]) begin
         gene_ready[gene] = 1'b1;
         ready_genes.push_back(gene);
      end
   endtask

   task automatic load_gene(input logic [9:0] gene);
      int first;
      int k;
      first = $urandom_range(3);
      for (k = 0; k < WORD_COUNT; k++) begin
         load_word(gene, 2'((first + k) % WORD_COUNT), random_tumor_word(),
                   random_normal_word());
      end
   endtask

   task automatic score_triplet(input logic [9:0] a, input logic [9:0] b, input logic [9:0] c);
      send_request(make_request(OP_SCORE, a, b, c));
   endtask

   task automatic commit_best();
      send_request(make_request(OP_COMMIT, 10'($urandom_range(1023)),
                                10'($urandom_range(1023)), 10'($urandom_range(1023))));
   endtask

   task automatic no_op();
      send_request(make_request(OP_NOP, 10'($urandom_range(1023)),
                                10'($urandom_range(1023)), 10'($urandom_range(1023))));
   endtask

   // One greedy round: a few fresh genes, some scores with ties, then in about half the rounds a commit.
   task automatic run_random_round();
      int         n_loads;
      int         n_scores;
      int         k;
      logic [9:0] a;
      logic [9:0] b;
      logic [9:0] c;
      n_loads = (ready_genes.size() < 8) ? 3 : $urandom_range(2);
      for (k = 0; k < n_loads; k++) load_gene(10'($urandom_range(1023)));
      // A stray single-word load leaves its gene unusable until fully loaded.
      if ($urandom_range(9) == 0) begin
         load_word(10'($urandom_range(1023)), 2'($urandom_range(3)), random_tumor_word(),
                   random_normal_word());
      end
      n_scores = $urandom_range(1, 8);
      for (k = 0; k < n_scores; k++) begin
         a = pick_ready_gene();
         b = pick_ready_gene();
         c = pick_ready_gene();
         if ($urandom_range(7) == 0) begin
            b = a;
            c = a;
         end
         score_triplet(a, b, c);
         // The same genes in another order give an equal score, which must not win.
         if ($urandom_range(9) == 0) score_triplet(c, a, b);
         if ($urandom_range(9) == 0) no_op();
      end
      if ($urandom_range(1) == 0) begin
         commit_best();
         if ($urandom_range(7) == 0) commit_best();
      end
   endtask

   task automatic run_items(input int count);
      int target;
      target = sent_items + count;
      while (sent_items < target) run_random_round();
   endtask

   // Reset values: empty round, zero totals, nothing present.
   task automatic test_reset_state();
      no_op();
      commit_best();
      wait_for_results();
   endtask

   task automatic test_directed_cover();
      int w;
      set_config(16'hFFFF, 16'd256, 16'd256);
      for (w = 0; w < WORD_COUNT; w++) load_word(10'd0, 2'(w), '1, '0);
      for (w = 0; w < WORD_COUNT; w++) load_word(10'd512, 2'(w), '1, '0);
      for (w = 0; w < WORD_COUNT; w++) load_word(10'd1023, 2'(w), {32{2'b10}}, '1);
      score_triplet(10'd0, 10'd0, 10'd0);
      score_triplet(10'd1023, 10'd1023, 10'd1023);
      score_triplet(10'd512, 10'd0, 10'd512);
      score_triplet(10'd0, 10'd1023, 10'd0);
      no_op();
      commit_best();
      commit_best();
      score_triplet(10'd0, 10'd0, 10'd0);
      score_triplet(10'd1023, 10'd0, 10'd1023);
      commit_best();
      wait_for_results();
   endtask

   // The response side holds off long enough for the block to stall its input.
   task automatic test_output_backpressure();
      no_idle = 1'b1;
      hold_off_requests++;
      run_items(30);
      no_idle = 1'b0;
      wait_for_results();
   endtask

   task automatic test_random_phases();
      int p;
      for (p = 0; p < 6; p++) begin
         case (p)
            0: set_config(ALPHA_RESET, 16'd256, 16'd256);
            1: set_config(16'd0, 16'd256, 16'd200);
            2: set_config(16'hFFFF, 16'd0, 16'd0);
            3: set_config(16'd4096, 16'd100, 16'd256);
            4: set_config(16'd1, 16'd256, 16'd0);
            default: set_config(16'd2048, 16'd200, 16'd128);
         endcase
         no_idle = (p == 3);
         run_items(140);
         wait_for_results();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      int g;
      int w;
      for (g = 0; g < GENE_COUNT; g++) begin
         loaded_words[g] = '0;
         gene_ready[g] = 1'b0;
      end
      for (w = 0; w < WORD_COUNT; w++) begin
         present_bits[w] = '0;
         covered_bits[w] = '0;
      end
      covered_total = 0;
      kept_a = '0;
      kept_b = '0;
      kept_c = '0;
      kept_score = '0;
      kept_seen = 1'b0;
      alpha_cfg = ALPHA_RESET;
      tumor_total_cfg = '0;
      normal_total_cfg = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_directed_cover();
      test_output_backpressure();
      test_random_phases();

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         fail_count++;
         $display("%0t ns: %0d responses never arrived", $time, pending_results.size());
      end
      if (fail_count == 0) begin
         $display("** triplet_cover_score_argmax: PASSED **");
      end else begin
         $display("** triplet_cover_score_argmax: FAILED **");
      end
      $finish;
   end

endmodule
